// File: hw/rtl/lmcfw_pkg.sv
// ----------------------------------------------------------------------------
// lmcfw_pkg
// Shared types and constants for the cascaded LED matrix frame writer.
// ----------------------------------------------------------------------------
package lmcfw_pkg;

  localparam int unsigned MAX_DEVICES_DEF = 8;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [3:0] COUNT_RESET   = 4'd8;
  localparam logic [7:0] OPC_SHUTDOWN  = 8'd12;
  localparam logic [7:0] OPC_SCANLIMIT = 8'd11;
  localparam logic [7:0] OPC_INTENSITY = 8'd10;
  localparam logic [7:0] LEFT_BIT      = 8'b1000_0000;
  localparam logic [7:0] ONE_BIT       = 8'h01;

  typedef enum logic [2:0] {
    FN_RAW       = 3'd0,
    FN_SET_LED   = 3'd1,
    FN_SET_ROW   = 3'd2,
    FN_SET_COL   = 3'd3,
    FN_CLEAR     = 3'd4,
    FN_SHUTDOWN  = 3'd5,
    FN_SCANLIMIT = 3'd6,
    FN_INTENSITY = 3'd7
  } func_e;

  typedef struct packed {
    logic load;     // latch command at input beat
    logic rd;       // read shadow row
    logic upd;      // update shadow, build frame word
    logic emit;     // load next word into output register
    logic row_inc;  // advance to next row of the command
  } ctrl_cmd_t;

  typedef struct packed {
    logic drop;      // incoming command gives no output
    logic multi;     // command spans eight frames
    logic row_last;  // current row is row 7
    logic pos_zero;  // current word is for device 0
    logic out_free;  // output register can take a word
  } dp_status_t;

endpackage

// File: hw/rtl/lmcfw_ram.sv
// ----------------------------------------------------------------------------
// lmcfw_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lmcfw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lmcfw_datapath.sv
// ----------------------------------------------------------------------------
// lmcfw_datapath
// Command registers, shadow image, frame word build and output register.
// ----------------------------------------------------------------------------
module lmcfw_datapath #(
  parameter int unsigned MAX_DEVICES = lmcfw_pkg::MAX_DEVICES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lmcfw_pkg::ctrl_cmd_t                cmd_i,
  output lmcfw_pkg::dp_status_t               status_o,
  input  logic                                cfg_valid_i,
  input  logic [3:0]                          cfg_data_i,
  input  logic [lmcfw_pkg::IN_TDATA_W-1:0]    in_tdata_i,
  input  logic [2:0]                          in_tuser_i,
  input  logic                                m_axis_tready,
  output logic                                m_axis_tvalid,
  output logic [lmcfw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tuser
);

  import lmcfw_pkg::*;

  localparam int unsigned DEPTH = MAX_DEVICES * 8;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [3:0]  MaxCnt = 4'(MAX_DEVICES);

  logic [3:0] count_q;
  logic [3:0] used_cnt;
  logic       in_drop;

  func_e      func_q;
  logic [2:0] dev_q, col_q, rowcnt_q, pos_q;
  logic [3:0] opc_q;
  logic [7:0] val_q;
  logic [15:0] word_q;

  logic [DEPTH-1:0] valid_q;
  logic             valid_rd_q;
  logic [5:0]       addr_full;
  logic [AW-1:0]    addr;
  logic [7:0]       rdata, old_row, new_row, mask, frm_opc, frm_data;
  logic             bit_on, wr_en;

  func_e      in_func;
  logic [2:0] in_dev, in_row, in_col;
  logic [3:0] in_opc;
  logic [7:0] in_val;

  logic             out_valid_q, out_last_q, out_cmd_last_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  assign in_func = func_e'(in_tuser_i);
  assign in_dev  = in_tdata_i[2:0];
  assign in_row  = in_tdata_i[5:3];
  assign in_col  = in_tdata_i[8:6];
  assign in_opc  = in_tdata_i[12:9];
  assign in_val  = in_tdata_i[20:13];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign used_cnt = (count_q == 4'd0 || count_q > MaxCnt) ? MaxCnt : count_q;

  always_comb begin
    in_drop = ({1'b0, in_dev} >= used_cnt);
    if (in_func == FN_SCANLIMIT && in_val > 8'd7) begin
      in_drop = 1'b1;
    end
    if (in_func == FN_INTENSITY && in_val > 8'd15) begin
      in_drop = 1'b1;
    end
  end

  assign status_o.drop     = in_drop;
  assign status_o.multi    = (func_q == FN_SET_COL) || (func_q == FN_CLEAR);
  assign status_o.row_last = (rowcnt_q == 3'd7);
  assign status_o.pos_zero = (pos_q == 3'd0);
  assign status_o.out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func;
      dev_q  <= in_dev;
      col_q  <= in_col;
      opc_q  <= in_opc;
      val_q  <= in_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowcnt_q <= 3'd0;
    end else if (cmd_i.load) begin
      rowcnt_q <= (in_func == FN_SET_COL || in_func == FN_CLEAR) ? 3'd0 : in_row;
    end else if (cmd_i.row_inc) begin
      rowcnt_q <= rowcnt_q + 3'd1;
    end
  end

  assign addr_full = {dev_q, rowcnt_q};
  assign addr      = addr_full[AW-1:0];

  // shadow rows; a never-written row reads as zero through its valid bit
  lmcfw_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_shadow (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .re_i   (cmd_i.rd),
    .addr_i (addr),
    .wdata_i(new_row),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      valid_rd_q <= 1'b0;
    end else begin
      if (cmd_i.rd) begin
        valid_rd_q <= valid_q[addr];
      end
      if (wr_en) begin
        valid_q[addr] <= 1'b1;
      end
    end
  end

  assign old_row = valid_rd_q ? rdata : 8'h00;
  assign mask    = LEFT_BIT >> col_q;
  assign bit_on  = (func_q == FN_SET_COL) ? val_q[~rowcnt_q] : |(val_q & ONE_BIT);

  always_comb begin
    wr_en    = 1'b0;
    new_row  = old_row;
    frm_opc  = {5'd0, rowcnt_q} + 8'd1;
    frm_data = val_q;
    case (func_q)
      FN_RAW: begin
        frm_opc = {4'd0, opc_q};
      end
      FN_SET_LED, FN_SET_COL: begin
        new_row  = bit_on ? (old_row | mask) : (old_row & ~mask);
        wr_en    = cmd_i.upd;
        frm_data = new_row;
      end
      FN_SET_ROW: begin
        new_row  = val_q;
        wr_en    = cmd_i.upd;
        frm_data = new_row;
      end
      FN_CLEAR: begin
        new_row  = 8'h00;
        wr_en    = cmd_i.upd;
        frm_data = new_row;
      end
      FN_SHUTDOWN: begin
        frm_opc  = OPC_SHUTDOWN;
        frm_data = (val_q != 8'd0) ? 8'd0 : 8'd1;
      end
      FN_SCANLIMIT: begin
        frm_opc = OPC_SCANLIMIT;
      end
      FN_INTENSITY: begin
        frm_opc = OPC_INTENSITY;
      end
      default: begin
        frm_opc = {4'd0, opc_q};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      word_q <= {frm_opc, frm_data};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
    end else if (cmd_i.upd) begin
      pos_q <= 3'(used_cnt - 4'd1);
    end else if (cmd_i.emit) begin
      pos_q <= pos_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q     <= {5'd0, pos_q, (pos_q == dev_q) ? word_q : 16'h0000};
      out_last_q     <= status_o.pos_zero;
      out_cmd_last_q <= status_o.pos_zero && (!status_o.multi || status_o.row_last);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_cmd_last_q;

endmodule

// File: hw/rtl/lmcfw_ctrl.sv
// ----------------------------------------------------------------------------
// lmcfw_ctrl
// Sequencer: command accept, shadow read/update and word emission per frame.
// ----------------------------------------------------------------------------
module lmcfw_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lmcfw_pkg::dp_status_t  status_i,
  output lmcfw_pkg::ctrl_cmd_t   cmd_o
);

  import lmcfw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CALC = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !status_i.drop) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CALC;
      end
      S_CALC: begin
        cmd_o.upd = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.pos_zero) begin
            if (status_i.multi && !status_i.row_last) begin
              cmd_o.row_inc = 1'b1;
              state_d       = S_READ;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/led_matrix_cascade_frame_writer.sv
// ----------------------------------------------------------------------------
// led_matrix_cascade_frame_writer: chain frame writer with row shadow image.
// Per frame: shadow read, update, one word per device at one per cycle while
// the output is free; input is held until the last word (eight frames for set
// column and clear, else one); a dropped command is accepted with no output.
// Reset: device_count 8, shadow reads zero at once via per-row valid bits.
// ----------------------------------------------------------------------------
module led_matrix_cascade_frame_writer #(
  parameter int unsigned MAX_DEVICES = lmcfw_pkg::MAX_DEVICES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [3:0]                         cfg_data_i,      // device_count
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // device[2:0] row[5:3] column[8:6] opcode[12:9] value[20:13], zero fill
  input  logic [lmcfw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic [2:0]                         s_axis_tuser,    // func[2:0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // frame_word[15:0] chain_position[18:16], zero fill
  output logic [lmcfw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                               m_axis_tlast,    // end_of_frame
  output logic                               m_axis_tuser     // last
);

  import lmcfw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = in_ready;

  lmcfw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(in_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lmcfw_datapath #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .m_axis_tready(m_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
